// File: rtl/wedge_diffraction_angles_defines.svh
// Assertion macros for the wedge diffraction angle block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef WEDGE_DIFFRACTION_ANGLES_DEFINES_SVH
`define WEDGE_DIFFRACTION_ANGLES_DEFINES_SVH
// property that must hold at every edge out of reset
`define WDA_ASSERT(label, prop) label: assert property (@(posedge clk) disable iff (!rst_n) \
    (prop)) else $error("wda check failed");
// antecedent now, consequent in the next cycle
`define WDA_ASSERT_NEXT(label, ante, cons) label: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |=> (cons)) else $error("wda check failed");
`endif

// File: rtl/wda_pkg.sv
// Shared types and constants for the wedge diffraction angle pipeline.
// No dependencies.
`default_nettype none
package wda_pkg;
    localparam int LANE_LAT    = 75;
    localparam int XW          = 18;
    localparam int ZW          = 20;
    localparam int HALF_PI_Q16 = 102944;
    localparam int PI_Q13      = 25736;
    localparam int ONE_Q14     = 16384;

    typedef struct packed {
        logic [31:0] sq;
        logic [31:0] mag;
        logic        neg;
    } lane_in_t;

    typedef struct packed {
        logic        deg;
        logic        dif_left;
        logic [15:0] ext;
    } sb_t;

    function automatic int atan_q16(input int i);
        int r;
        begin
            unique case (i)
                0: r = 51472;
                1: r = 30386;
                2: r = 16055;
                3: r = 8150;
                4: r = 4091;
                5: r = 2047;
                6: r = 1024;
                7: r = 512;
                8: r = 256;
                9: r = 128;
                10: r = 64;
                11: r = 32;
                12: r = 16;
                13: r = 8;
                14: r = 4;
                default: r = 2;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// File: rtl/wda_sqrt_cell.sv
// One digit step of a pipelined integer square root.
// Standalone; W is the radicand width, STEP the step index from the top.
`default_nettype none
module wda_sqrt_cell #(
    parameter int W    = 48,
    parameter int STEP = 0
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] v_in,
    input  wire logic [W-1:0] r_in,
    output logic      [W-1:0] v_out,
    output logic      [W-1:0] r_out
);
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STEP);

    logic [W-1:0] trial;
    logic [W-1:0] v_next, r_next, v_reg, r_reg;

    always_comb
    begin
        trial = r_in + BIT;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;
endmodule
`default_nettype wire

// File: rtl/wda_div_cell.sv
// One quotient bit of a pipelined restoring divider.
// Standalone; K is the quotient bit this cell decides.
`default_nettype none
module wda_div_cell #(
    parameter int RW = 39,
    parameter int NW = 24,
    parameter int K  = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [RW-1:0] rem_in,
    input  wire logic [NW-1:0] n_in,
    input  wire logic [14:0]   q_in,
    output logic      [RW-1:0] rem_out,
    output logic      [NW-1:0] n_out,
    output logic      [14:0]   q_out
);
    logic [RW-1:0] sub;
    logic [RW-1:0] rem_next, rem_reg;
    logic [14:0]   q_next, q_reg;
    logic [NW-1:0] n_reg;

    always_comb
    begin
        sub = RW'(n_in) << K;
        if (rem_in >= sub)
        begin
            rem_next = rem_in - sub;
            q_next   = q_in | (15'd1 << K);
        end
        else
        begin
            rem_next = rem_in;
            q_next   = q_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            n_reg   <= n_in;
        end
    end

    assign rem_out = rem_reg;
    assign n_out   = n_reg;
    assign q_out   = q_reg;
endmodule
`default_nettype wire

// File: rtl/wda_cordic_cell.sv
// One vectoring iteration of the arccos CORDIC row.
// Depends on wda_pkg for widths and the arctangent table.
`default_nettype none
module wda_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [wda_pkg::XW-1:0]    x_in,
    input  wire logic signed [wda_pkg::XW-1:0]    y_in,
    input  wire logic signed [wda_pkg::ZW-1:0]    z_in,
    output logic      signed [wda_pkg::XW-1:0]    x_out,
    output logic      signed [wda_pkg::XW-1:0]    y_out,
    output logic      signed [wda_pkg::ZW-1:0]    z_out
);
    localparam logic signed [wda_pkg::ZW-1:0] ATAN = wda_pkg::ZW'(wda_pkg::atan_q16(STEP));

    logic signed [wda_pkg::XW-1:0] dx, dy, x_next, y_next, x_reg, y_reg;
    logic signed [wda_pkg::ZW-1:0] z_next, z_reg;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[wda_pkg::XW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

// File: rtl/wda_lane.sv
// One angle lane: vector length, rounded cosine, arccos.
// Depends on wda_pkg, wda_sqrt_cell, wda_div_cell, wda_cordic_cell.
`default_nettype none
module wda_lane (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire wda_pkg::lane_in_t lin,
    output logic [14:0]            acos_out
);
    localparam int XW = wda_pkg::XW;
    localparam int ZW = wda_pkg::ZW;

    // length: isqrt(sq << 16)
    logic [47:0] v1 [0:24];
    logic [47:0] r1 [0:24];
    logic [31:0] mag_d [0:24];
    logic        neg_d [0:24];

    assign v1[0]    = {lin.sq, 16'd0};
    assign r1[0]    = '0;
    assign mag_d[0] = lin.mag;
    assign neg_d[0] = lin.neg;

    for (genvar i = 0; i < 24; i++)
    begin : g_len
        wda_sqrt_cell #(.W(48), .STEP(i)) u_cell (
            .clk(clk), .en(en), .v_in(v1[i]), .r_in(r1[i]),
            .v_out(v1[i+1]), .r_out(r1[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_d[i+1] <= mag_d[i];
                neg_d[i+1] <= neg_d[i];
            end
        end
    end

    // rounding offset and saturation check
    logic [23:0] n_w;
    logic [48:0] num, lim;
    logic [38:0] pre_rem_reg;
    logic [23:0] pre_n_reg;
    logic        pre_sat_reg, pre_neg_reg;

    assign n_w = r1[24][23:0];
    assign num = {1'b0, mag_d[24], 16'd0} + 49'(n_w[23:1]);
    assign lim = {10'd0, n_w, 15'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_rem_reg <= num[38:0];
            pre_n_reg   <= n_w;
            pre_sat_reg <= (num >= lim);
            pre_neg_reg <= neg_d[24];
        end
    end

    logic [38:0] rem [0:15];
    logic [23:0] nn  [0:15];
    logic [14:0] q   [0:15];
    logic        sat_d [0:15];
    logic        sg_d  [0:15];

    assign rem[0]   = pre_rem_reg;
    assign nn[0]    = pre_n_reg;
    assign q[0]     = '0;
    assign sat_d[0] = pre_sat_reg;
    assign sg_d[0]  = pre_neg_reg;

    for (genvar i = 0; i < 15; i++)
    begin : g_div
        wda_div_cell #(.RW(39), .NW(24), .K(14 - i)) u_cell (
            .clk(clk), .en(en), .rem_in(rem[i]), .n_in(nn[i]), .q_in(q[i]),
            .rem_out(rem[i+1]), .n_out(nn[i+1]), .q_out(q[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_d[i+1] <= sat_d[i];
                sg_d[i+1]  <= sg_d[i];
            end
        end
    end

    // signed cosine, then 1 - c^2
    logic [14:0]        cm;
    logic signed [15:0] c_next, c_reg, c2_reg;
    logic signed [31:0] cc;
    logic [29:0]        rad_reg;

    assign cm     = (sat_d[15] || q[15] > 15'(wda_pkg::ONE_Q14)) ? 15'(wda_pkg::ONE_Q14) : q[15];
    assign c_next = sg_d[15] ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
    assign cc     = c_reg * c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg   <= c_next;
            c2_reg  <= c_reg;
            rad_reg <= 30'(32'sd268435456 - cc);
        end
    end

    // sine: isqrt(2^28 - c^2)
    logic [29:0]        v2 [0:15];
    logic [29:0]        r2 [0:15];
    logic signed [15:0] cd [0:15];

    assign v2[0] = rad_reg;
    assign r2[0] = '0;
    assign cd[0] = c2_reg;

    for (genvar i = 0; i < 15; i++)
    begin : g_sin
        wda_sqrt_cell #(.W(30), .STEP(i)) u_cell (
            .clk(clk), .en(en), .v_in(v2[i]), .r_in(r2[i]),
            .v_out(v2[i+1]), .r_out(r2[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd[i+1] <= cd[i];
            end
        end
    end

    // CORDIC seed and row
    logic signed [XW-1:0] xs [0:16];
    logic signed [XW-1:0] ys [0:16];
    logic signed [ZW-1:0] zs [0:16];
    logic signed [XW-1:0] s_w, c_w;
    logic signed [XW-1:0] x0_reg, y0_reg;
    logic signed [ZW-1:0] z0_reg;

    assign s_w = XW'($signed({1'b0, r2[15][14:0]}));
    assign c_w = XW'(cd[15]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cd[15] < 0)
            begin
                x0_reg <= s_w;
                y0_reg <= -c_w;
                z0_reg <= ZW'(wda_pkg::HALF_PI_Q16);
            end
            else
            begin
                x0_reg <= c_w;
                y0_reg <= s_w;
                z0_reg <= '0;
            end
        end
    end

    assign xs[0] = x0_reg;
    assign ys[0] = y0_reg;
    assign zs[0] = z0_reg;

    for (genvar i = 0; i < 16; i++)
    begin : g_cordic
        wda_cordic_cell #(.STEP(i)) u_cell (
            .clk(clk), .en(en), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
            .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
        );
    end

    // clamp, round to Q2.13, clamp at pi
    logic signed [ZW-1:0] zc, zr;
    logic [14:0]          acos_reg;

    assign zc = zs[16][ZW-1] ? '0 : zs[16];
    assign zr = (zc + ZW'(4)) >>> 3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acos_reg <= (zr > ZW'(wda_pkg::PI_Q13)) ? 15'(wda_pkg::PI_Q13) : zr[14:0];
        end
    end

    assign acos_out = acos_reg;
endmodule
`default_nettype wire

// File: rtl/wedge_diffraction_angles.sv
// Top level of the 2D wedge diffraction angle pipeline.
// Depends on wda_pkg and wda_lane.
// Fully pipelined: one transfer accepted per cycle while the pipeline advances. Most of
// the stages lie in the cell rows of each lane: a 24-step
// length root, a 15-bit divider, a 15-step sine root and 16 CORDIC steps. The
// whole pipeline advances when the output register is empty or being taken.
`default_nettype none
module wedge_diffraction_angles (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // in_x, in_y, diff_x, diff_y, edge1_x, edge1_y, edge2_x, edge2_y, exterior_angle
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // incident_angle[14:0], diffraction_angle[31:15], degenerate[32], zero pad
    output logic [39:0]       m_tdata
);
    localparam int NST = wda_pkg::LANE_LAT + 6;

    logic           en;
    logic [NST-1:0] vld_reg;

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    // S1: capture
    logic signed [15:0] ix1, iy1, dx1, dy1, e1x1, e1y1, e2x1, e2y1;
    logic [15:0]        ext1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix1  <= s_tdata[15:0];
            iy1  <= s_tdata[31:16];
            dx1  <= s_tdata[47:32];
            dy1  <= s_tdata[63:48];
            e1x1 <= s_tdata[79:64];
            e1y1 <= s_tdata[95:80];
            e2x1 <= s_tdata[111:96];
            e2y1 <= s_tdata[127:112];
            ext1 <= s_tdata[143:128];
        end
    end

    // S2: bisector cross products and squares
    logic signed [17:0] mx, my;
    logic signed [32:0] pe1, pe2, pi1, pi2, pd1, pd2;
    logic [31:0]        sqi2, sqd2;
    logic               deg2;
    logic signed [15:0] ix2, iy2, dx2, dy2, e1x2, e1y2, e2x2, e2y2;
    logic [15:0]        ext2;

    assign mx = -(18'(e1x1) + 18'(e2x1));
    assign my = -(18'(e1y1) + 18'(e2y1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pe1  <= mx * 33'(e1y1);
            pe2  <= my * 33'(e1x1);
            pi1  <= mx * 33'(iy1);
            pi2  <= my * 33'(ix1);
            pd1  <= mx * 33'(dy1);
            pd2  <= my * 33'(dx1);
            sqi2 <= 32'($unsigned(32'(ix1 * ix1))) + 32'($unsigned(32'(iy1 * iy1)));
            sqd2 <= 32'($unsigned(32'(dx1 * dx1))) + 32'($unsigned(32'(dy1 * dy1)));
            deg2 <= (mx == 0 && my == 0) || (ix1 == 0 && iy1 == 0) || (dx1 == 0 && dy1 == 0);
            ix2  <= ix1;
            iy2  <= iy1;
            dx2  <= dx1;
            dy2  <= dy1;
            e1x2 <= e1x1;
            e1y2 <= e1y1;
            e2x2 <= e2x1;
            e2y2 <= e2y1;
            ext2 <= ext1;
        end
    end

    // S3: side decisions, edge selection
    logic signed [33:0] ce, ci, cdf;
    logic               e1_left, in_left;
    logic signed [15:0] lx, ly, rx, ry;
    logic signed [15:0] zx3, zy3, ex3, ey3, ix3, iy3, dx3, dy3;
    logic [31:0]        sqi3, sqd3;
    wda_pkg::sb_t       sb3;

    assign ce      = 34'(pe1) - 34'(pe2);
    assign ci      = 34'(pi1) - 34'(pi2);
    assign cdf     = 34'(pd1) - 34'(pd2);
    assign e1_left = ce > 0;
    assign in_left = !ci[33];
    assign lx      = e1_left ? e1x2 : e2x2;
    assign ly      = e1_left ? e1y2 : e2y2;
    assign rx      = e1_left ? e2x2 : e1x2;
    assign ry      = e1_left ? e2y2 : e1y2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zx3          <= in_left ? lx : rx;
            zy3          <= in_left ? ly : ry;
            ex3          <= !cdf[33] ? lx : rx;
            ey3          <= !cdf[33] ? ly : ry;
            sb3.deg      <= deg2;
            sb3.dif_left <= !cdf[33];
            sb3.ext      <= ext2;
            ix3          <= ix2;
            iy3          <= iy2;
            dx3          <= dx2;
            dy3          <= dy2;
            sqi3         <= sqi2;
            sqd3         <= sqd2;
        end
    end

    // S4: dot products
    logic signed [31:0] ti1, ti2, td1, td2;
    logic [31:0]        sqi4, sqd4;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ti1  <= zx3 * ix3;
            ti2  <= zy3 * iy3;
            td1  <= ex3 * dx3;
            td2  <= ey3 * dy3;
            sqi4 <= sqi3;
            sqd4 <= sqd3;
        end
    end

    // S5: dot sums into lane format
    logic signed [32:0]  di, dd;
    wda_pkg::lane_in_t   li_reg, ld_reg;

    assign di = 33'(ti1) + 33'(ti2);
    assign dd = 33'(td1) + 33'(td2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            li_reg.sq  <= sqi4;
            li_reg.mag <= di[32] ? 32'(-di) : di[31:0];
            li_reg.neg <= di[32];
            ld_reg.sq  <= sqd4;
            ld_reg.mag <= dd[32] ? 32'(-dd) : dd[31:0];
            ld_reg.neg <= dd[32];
        end
    end

    logic [14:0] acos_i, acos_d;

    wda_lane u_lane_inc (.clk(clk), .en(en), .lin(li_reg), .acos_out(acos_i));
    wda_lane u_lane_dif (.clk(clk), .en(en), .lin(ld_reg), .acos_out(acos_d));

    wda_pkg::sb_t sb_d [0:wda_pkg::LANE_LAT+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_d[0] <= sb3;
            for (int k = 1; k <= wda_pkg::LANE_LAT + 1; k++)
                sb_d[k] <= sb_d[k-1];
        end
    end

    // output register
    wda_pkg::sb_t       sbo;
    logic signed [16:0] dif;
    logic [39:0]        out_reg;

    assign sbo = sb_d[wda_pkg::LANE_LAT+1];
    assign dif = sbo.dif_left ? $signed({2'b00, acos_d})
                              : $signed({1'b0, sbo.ext}) - $signed({2'b00, acos_d});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sbo.deg)
                out_reg <= {7'd0, 1'b1, 32'd0};
            else
                out_reg <= {7'd0, 1'b0, dif, acos_i};
        end
    end

    assign m_tdata = out_reg;
endmodule
`default_nettype wire

// File: rtl/wda_checker.sv
// Port-level checks for the wedge diffraction angle block, bound to the top level.
// Depends on wedge_diffraction_angles_defines.svh.
`default_nettype none
`include "wedge_diffraction_angles_defines.svh"
module wda_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [39:0]  m_tdata
);
    `WDA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `WDA_ASSERT(a_deg_zero, !(m_tvalid && m_tdata[32]) || m_tdata[31:0] == 32'd0)
    `WDA_ASSERT(a_inc_range, !m_tvalid || m_tdata[14:0] <= 15'd25736)
    `WDA_ASSERT(a_flow, s_tready == (!m_tvalid || m_tready))
endmodule

bind wedge_diffraction_angles wda_checker u_wda_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
